[hdl/ces_pkg.sv]
package ces_pkg;

    localparam int NUM_CHANNELS_DEF        = 16;
    localparam int SAMPLES_PER_CHANNEL_DEF = 4;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 10;

    // register indexes on the configuration port
    localparam logic [CFG_AW-1:0] CFG_FIRST_CHANNEL   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_START_THRESHOLD = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_CYCLE_TICKS     = 2'd2;

    localparam logic [5:0]        FIRST_CHANNEL_RST   = 6'd11;
    localparam logic signed [7:0] START_THRESHOLD_RST = -8'sd100;
    localparam logic [9:0]        CYCLE_TICKS_RST     = 10'd304;

    typedef struct packed {
        logic signed [7:0] rssi_sample;
    } t_in_beat;

    typedef struct packed {
        logic              set_channel;
        logic [5:0]        channel_number;
        logic              jam_start;
        logic              jam_stop;
        logic signed [7:0] best_average;
    } t_out_beat;

    typedef struct packed {
        logic [5:0]        first_channel;
        logic signed [7:0] start_threshold;
        logic [9:0]        cycle_ticks;
    } t_cfg;

endpackage

[hdl/ces_chan_if.sv]
interface ces_chan_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/ces_avg.sv]
module ces_avg #(
    parameter int SAMPLES_PER_CHANNEL = 4,
    parameter int SUM_W               = 10
) (
    input  logic signed [SUM_W-1:0] i_sum,
    output logic signed [7:0]       o_avg
);
    // divide by a constant through a reciprocal multiply, exact for SUM_W-bit magnitudes
    localparam int          K    = SUM_W + 5;
    localparam int          RECI = ((2 ** K) + SAMPLES_PER_CHANNEL - 1) / SAMPLES_PER_CHANNEL;
    localparam logic [K:0]  M    = (K+1)'(RECI);

    logic               w_neg;
    logic [SUM_W-1:0]   w_mag;
    logic [SUM_W+K:0]   w_prod;
    logic [SUM_W-1:0]   w_quo;
    logic [7:0]         w_q8;

    always_comb begin
        w_neg  = i_sum[SUM_W-1];
        w_mag  = w_neg ? (SUM_W)'(-i_sum) : (SUM_W)'(i_sum);
        w_prod = (SUM_W+K+1)'(w_mag) * (SUM_W+K+1)'(M);
        w_quo  = w_prod[K +: SUM_W];
        w_q8   = w_quo[7:0];
        // truncation toward zero: divide the magnitude, then restore the sign
        o_avg  = w_neg ? $signed(-w_q8) : $signed(w_q8);
    end
endmodule

[hdl/ces_seq.sv]
module ces_seq #(
    parameter int NUM_CHANNELS        = 16,
    parameter int SAMPLES_PER_CHANNEL = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic signed [7:0]  i_sample,
    input  ces_pkg::t_cfg      i_cfg,
    output ces_pkg::t_out_beat o_result
);
    import ces_pkg::*;

    localparam int SUM_W = 8 + $clog2(SAMPLES_PER_CHANNEL);
    localparam int CNT_W = (SAMPLES_PER_CHANNEL > 1) ? $clog2(SAMPLES_PER_CHANNEL) : 1;
    localparam logic [9:0]       SCAN_TICKS = 10'(NUM_CHANNELS * SAMPLES_PER_CHANNEL);
    localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(SAMPLES_PER_CHANNEL - 1);

    typedef logic signed [SUM_W-1:0] t_sum;

    logic [9:0]        r_tick,  n_tick;
    logic [CNT_W-1:0]  r_cnt,   n_cnt;
    logic [5:0]        r_cur,   n_cur;
    t_sum              r_sum,   n_sum;
    logic signed [7:0] r_best,  n_best;
    logic [5:0]        r_bch,   n_bch;

    t_sum              w_sum_acc;
    logic signed [7:0] w_avg;
    logic [9:0]        w_tick_inc;

    assign w_sum_acc = r_sum + t_sum'(i_sample);

    ces_avg #(
        .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL),
        .SUM_W              (SUM_W)
    ) u_avg (
        .i_sum(w_sum_acc),
        .o_avg(w_avg)
    );

    always_comb begin
        n_tick   = r_tick;
        n_cnt    = r_cnt;
        n_cur    = r_cur;
        n_sum    = r_sum;
        n_best   = r_best;
        n_bch    = r_bch;
        o_result = '0;

        if (r_tick < SCAN_TICKS) begin
            n_sum = w_sum_acc;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                if (w_avg > r_best) begin
                    n_best = w_avg;
                    n_bch  = r_cur;
                end
                n_cur                   = r_cur + 6'd1;
                n_sum                   = '0;
                n_cnt                   = '0;
                o_result.set_channel    = 1'b1;
                o_result.channel_number = r_cur + 6'd1;
            end
            o_result.best_average = n_best;
        end else if (r_tick == SCAN_TICKS) begin
            o_result.set_channel    = 1'b1;
            o_result.channel_number = r_bch;
            o_result.best_average   = r_best;
            n_bch                   = i_cfg.first_channel;
            n_best                  = i_cfg.start_threshold;
        end else begin
            o_result.jam_start    = 1'b1;
            o_result.best_average = r_best;
        end

        w_tick_inc = r_tick + 10'd1;
        n_tick     = w_tick_inc;
        // end of cycle overrides any channel command of this beat
        if (w_tick_inc >= i_cfg.cycle_ticks) begin
            n_tick                  = '0;
            n_cur                   = i_cfg.first_channel;
            n_sum                   = '0;
            n_cnt                   = '0;
            o_result.jam_stop       = 1'b1;
            o_result.set_channel    = 1'b1;
            o_result.channel_number = i_cfg.first_channel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_cnt  <= '0;
            r_cur  <= FIRST_CHANNEL_RST;
            r_sum  <= '0;
            r_best <= START_THRESHOLD_RST;
            r_bch  <= FIRST_CHANNEL_RST;
        end else if (i_step) begin
            r_tick <= n_tick;
            r_cnt  <= n_cnt;
            r_cur  <= n_cur;
            r_sum  <= n_sum;
            r_best <= n_best;
            r_bch  <= n_bch;
        end
    end
endmodule

[hdl/channel_energy_scan_jam_sequencer_core.sv]
// a sample beat is held in the sample register, then its result in the result
// register; one beat per cycle while the output is not stalled
// the sample register and the result register each hold one beat, so a stalled
// output still lets one more sample in
// reset (synchronous, active low): registers return to first channel 11,
// threshold -100, cycle length 304; scan state and both pipeline stages clear
module channel_energy_scan_jam_sequencer_core #(
    parameter int NUM_CHANNELS        = ces_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLES_PER_CHANNEL = ces_pkg::SAMPLES_PER_CHANNEL_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ces_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [ces_pkg::CFG_DW-1:0] i_cfg_data,
    ces_chan_if.sink                   i_sample_ch,
    ces_chan_if.source                 o_result_ch
);
    import ces_pkg::*;

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic signed [7:0] r_sample;
    logic              r_out_valid;
    t_out_beat         r_out_data;
    t_out_beat         w_result;
    t_in_beat          w_in_beat;
    logic              w_adv;
    logic              w_in_ready;
    logic              w_step;

    assign w_in_beat  = i_sample_ch.data;
    assign w_adv      = !r_out_valid || o_result_ch.ready;
    assign w_in_ready = !r_in_valid || w_adv;
    assign w_step     = r_in_valid && w_adv;

    assign i_sample_ch.ready = w_in_ready;
    assign o_result_ch.valid = r_out_valid;
    assign o_result_ch.data  = r_out_data;

    ces_seq #(
        .NUM_CHANNELS       (NUM_CHANNELS),
        .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_sample(r_sample),
        .i_cfg   (r_cfg),
        .o_result(w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_channel   <= FIRST_CHANNEL_RST;
            r_cfg.start_threshold <= START_THRESHOLD_RST;
            r_cfg.cycle_ticks     <= CYCLE_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIRST_CHANNEL:   r_cfg.first_channel   <= i_cfg_data[5:0];
                CFG_START_THRESHOLD: r_cfg.start_threshold <= $signed(i_cfg_data[7:0]);
                CFG_CYCLE_TICKS:     r_cfg.cycle_ticks     <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_sample_ch.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_sample_ch.valid) begin
            r_sample <= w_in_beat.rssi_sample;
        end
        if (w_step) begin
            r_out_data <= w_result;
        end
    end
endmodule

[hdl/ces_checker.sv]
module ces_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input ces_pkg::t_out_beat i_out_data
);
    import ces_pkg::*;

    // end of cycle always retunes the radio
    a_stop_sets_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.jam_stop) |-> i_out_data.set_channel)
        else $error("jam stop beat without a channel command");

    a_idle_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_data.set_channel) |-> (i_out_data.channel_number == 6'd0))
        else $error("channel number set without a channel command");

    // jamming beats only retune when the cycle ends
    a_jam_no_retune: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.jam_start && !i_out_data.jam_stop)
            |-> !i_out_data.set_channel)
        else $error("channel command during jamming");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result beat changed while stalled");
endmodule

bind channel_energy_scan_jam_sequencer_core ces_checker u_ces_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_result_ch.valid),
    .i_out_ready(o_result_ch.ready),
    .i_out_data (o_result_ch.data)
);

[sim/tb_top.sv]
module tb_top;
    import ces_pkg::*;

    localparam int SCAN_TICKS  = NUM_CHANNELS_DEF * SAMPLES_PER_CHANNEL_DEF;
    localparam int STALL_LIMIT = 4000;

    // tracks scan, select and jam state and predicts the beat of every tick
    class jam_cycle_checker;
        t_out_beat         expected_ticks[$];
        int                errors = 0;
        logic [5:0]        first_ch;
        logic signed [7:0] threshold;
        logic [9:0]        cycle_len;
        logic [9:0]        tick_cnt;
        int                samp_cnt;
        logic [5:0]        cur_ch;
        int                samp_sum;
        int                best_lvl;
        logic [5:0]        best_ch;

        function void reset_state();
            first_ch  = FIRST_CHANNEL_RST;
            threshold = START_THRESHOLD_RST;
            cycle_len = CYCLE_TICKS_RST;
            tick_cnt  = '0;
            samp_cnt  = 0;
            cur_ch    = first_ch;
            samp_sum  = 0;
            best_lvl  = threshold;
            best_ch   = first_ch;
            expected_ticks.delete();
        endfunction

        function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_FIRST_CHANNEL:   first_ch = val[5:0];
                CFG_START_THRESHOLD: threshold = val[7:0];
                CFG_CYCLE_TICKS:     cycle_len = val;
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [7:0] rssi);
            t_out_beat r;
            int        avg;
            r = '0;
            if (tick_cnt < SCAN_TICKS) begin
                samp_sum += rssi;
                samp_cnt++;
                if (samp_cnt >= SAMPLES_PER_CHANNEL_DEF) begin
                    // signed divide truncates toward zero
                    avg = samp_sum / SAMPLES_PER_CHANNEL_DEF;
                    if (avg > best_lvl) begin
                        best_lvl = avg;
                        best_ch  = cur_ch;
                    end
                    cur_ch           = cur_ch + 6'd1;
                    samp_sum         = 0;
                    samp_cnt         = 0;
                    r.set_channel    = 1'b1;
                    r.channel_number = cur_ch;
                end
                r.best_average = best_lvl[7:0];
            end else if (tick_cnt == SCAN_TICKS) begin
                r.set_channel    = 1'b1;
                r.channel_number = best_ch;
                r.best_average   = best_lvl[7:0];
                best_ch          = first_ch;
                best_lvl         = threshold;
            end else begin
                r.jam_start    = 1'b1;
                r.best_average = best_lvl[7:0];
            end
            tick_cnt = tick_cnt + 10'd1;
            // restart overrides any channel command of this tick
            if (tick_cnt >= cycle_len) begin
                tick_cnt         = '0;
                cur_ch           = first_ch;
                samp_sum         = 0;
                samp_cnt         = 0;
                r.jam_stop       = 1'b1;
                r.set_channel    = 1'b1;
                r.channel_number = first_ch;
            end
            expected_ticks.push_back(r);
        endfunction

        function void field_check(string name, logic signed [15:0] want,
                                  logic signed [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_tick(t_out_beat got);
            t_out_beat want;
            if (expected_ticks.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected, expected none, actual %p",
                         $time, got);
                return;
            end
            want = expected_ticks.pop_front();
            field_check("set_channel", want.set_channel, got.set_channel);
            field_check("channel_number", want.channel_number, got.channel_number);
            field_check("jam_start", want.jam_start, got.jam_start);
            field_check("jam_stop", want.jam_stop, got.jam_stop);
            field_check("best_average", want.best_average, got.best_average);
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;

    ces_chan_if #(.t_data(t_in_beat))  sample_ch ();
    ces_chan_if #(.t_data(t_out_beat)) result_ch ();

    jam_cycle_checker cycle_check = new;

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int rx_hold_left = 0;
    int stall_cycles = 0;

    channel_energy_scan_jam_sequencer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample_ch (sample_ch),
        .o_result_ch (result_ch)
    );

    always #5 i_clk = ~i_clk;

    // result side: ready changes on the falling edge
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            result_ch.ready <= 1'b0;
            rx_hold_left--;
        end else begin
            result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready)
                cycle_check.check_tick(result_ch.data);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("channel_energy_scan_jam_sequencer_core verification failed");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic signed [7:0] rssi);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= '{rssi_sample: rssi};
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        cycle_check.note_sample(rssi);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (cycle_check.pending() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        cycle_check.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [5:0] first, input logic signed [7:0] thr,
                            input logic [9:0] cycle_len);
        write_reg(CFG_FIRST_CHANNEL, {4'd0, first});
        write_reg(CFG_START_THRESHOLD, {2'd0, thr});
        write_reg(CFG_CYCLE_TICKS, cycle_len);
    endtask

    function automatic logic signed [7:0] pick_rssi();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 8'sh80;
        else if (sel == 1)
            return 8'sh7f;
        else if (sel <= 3)
            return 8'($urandom_range(0, 24) - 112);   // around the default threshold
        else
            return 8'($urandom);
    endfunction

    task automatic run_phase(input logic [5:0] first, input logic signed [7:0] thr,
                             input logic [9:0] cycle_len, input int n_beats,
                             input int tx_pct, input int rx_pct, input bit squeeze);
        wait_drained();
        set_regs(first, thr, cycle_len);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        // long receiver hold so the block backs up into the sample channel
        if (squeeze)
            rx_hold_left = 80;
        for (int k = 0; k < n_beats; k++) begin
            if (squeeze && k == n_beats / 2) begin
                sample_ch.valid <= 1'b0;
                wait_drained();
            end
            send_sample(pick_rssi());
        end
        sample_ch.valid <= 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        result_ch.ready = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        cycle_check.reset_state();

        // zero-length cycle: every tick restarts on the top channel
        set_regs(6'd63, 8'sh7f, 10'd0);
        send_sample(8'sh7f);
        send_sample(8'sh80);
        send_sample(8'sh00);
        sample_ch.valid <= 1'b0;
        wait_drained();

        // short cycle: channel wraps past 63, truncation toward zero, restart mid scan
        write_reg(CFG_CYCLE_TICKS, 10'd9);
        repeat (4) send_sample(8'sh80);
        send_sample(-8'sd1);
        send_sample(-8'sd1);
        send_sample(-8'sd1);
        send_sample(-8'sd2);
        send_sample(8'sd5);
        sample_ch.valid <= 1'b0;

        run_phase(FIRST_CHANNEL_RST, START_THRESHOLD_RST, CYCLE_TICKS_RST, 100, 8, 59, 1'b1);
        run_phase(6'd63, 8'sh80, 10'd66, 80, 59, 8, 1'b0);
        run_phase(6'd0, 8'sh7f, 10'd1023, 80, 0, 0, 1'b0);
        // select tick coincides with restart
        run_phase(6'd47, -8'sd1, 10'd65, 70, 0, 0, 1'b0);
        run_phase(6'($urandom), 8'($urandom), 10'($urandom_range(66, 130)), 60, 0, 0, 1'b0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (cycle_check.errors == 0)
            $display("channel_energy_scan_jam_sequencer_core verification clean");
        else
            $display("channel_energy_scan_jam_sequencer_core verification failed");
        $finish;
    end

endmodule

[sim.f]
hdl/ces_pkg.sv
hdl/ces_chan_if.sv
hdl/ces_avg.sv
hdl/ces_seq.sv
hdl/channel_energy_scan_jam_sequencer_core.sv
hdl/ces_checker.sv
sim/tb_top.sv
